// ===== hdl/bmf_pkg.sv =====
`default_nettype none
package bmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WC_W     = 5;

  localparam logic [WC_W-1:0] WC_RESET = WC_W'(11);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WC_W-1:0]            wcount_t;

endpackage
`default_nettype wire

// ===== hdl/bmf_sample_if.sv =====
`default_nettype none
interface bmf_sample_if import bmf_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== hdl/bmf_median_if.sv =====
`default_nettype none
interface bmf_median_if import bmf_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/bmf_insert_unit.sv =====
`default_nettype none
// Sorted sample store: insertion by one read/compare step at a time,
// then an optional read of the median entry.
module bmf_insert_unit import bmf_pkg::*; #(
  parameter int MAX_WINDOW = 31,
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire sample_t       key,
  input  wire logic [AW-1:0] pos,
  input  wire logic          close,
  input  wire logic [AW-1:0] med_addr,
  output logic               idle,
  output logic               res_valid,
  output sample_t            res_data,
  input  wire logic          take
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_MRD  = 5'b01000,
    S_MOUT = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  sample_t         key_r, key_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic            close_r, close_nxt;
  logic [AW-1:0]   med_r, med_nxt;

  sample_t         mem [MAX_WINDOW];
  sample_t         rdata_r;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  sample_t         wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    j_nxt     = j_r;
    close_nxt = close_r;
    med_nxt   = med_r;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = j_r;
    raddr     = j_r - AW'(1);
    wdata     = key_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = key;
          j_nxt     = pos;
          close_nxt = close;
          med_nxt   = med_addr;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (j_r == '0) begin
          we        = 1'b1;
          state_nxt = close_r ? S_MRD : S_IDLE;
        end else begin
          re        = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        we = 1'b1;
        if (rdata_r > key_r) begin
          wdata     = rdata_r;
          j_nxt     = j_r - AW'(1);
          state_nxt = S_RD;
        end else begin
          state_nxt = close_r ? S_MRD : S_IDLE;
        end
      end
      S_MRD: begin
        re        = 1'b1;
        raddr     = med_r;
        state_nxt = S_MOUT;
      end
      S_MOUT: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    key_r   <= key_nxt;
    j_r     <= j_nxt;
    close_r <= close_nxt;
    med_r   <= med_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_MOUT);
  assign res_data  = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/block_median_filter.sv =====
`default_nettype none
// Median filter over windows of signed 16-bit samples. cfg_wdata sets the
// window size (0 acts as 1, sizes above MAX_WINDOW act as MAX_WINDOW); each
// sample is inserted into a sorted single-port store by a read/compare/shift
// step per larger entry held, and the word that completes a window then
// reads the entry at index count/2. A new sample is taken only once the
// insert unit is idle again; a median waiting at the output does not block
// input until the next window closes. Windows restart at zero fill after
// each result.
module block_median_filter import bmf_pkg::*; #(
  parameter int MAX_WINDOW = 31
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [WC_W-1:0]  cfg_wdata,
  bmf_sample_if.sink            in_if,
  bmf_median_if.source          out_if
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = (CW > WC_W) ? CW : WC_W;

  wcount_t        wc_r;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           out_valid_r;
  sample_t        out_data_r;

  logic [SW-1:0]  wc_ext, size_ext, held_ext;
  logic [CW-1:0]  held;
  logic           close;
  logic           accept;
  logic           unit_idle, res_valid, take;
  sample_t        res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= WC_RESET;
    end else if (cfg_we) begin
      wc_r <= cfg_wdata;
    end
  end

  always_comb begin
    wc_ext = SW'(wc_r);
    if (wc_ext == '0) begin
      size_ext = SW'(1);
    end else if (wc_ext > SW'(MAX_WINDOW)) begin
      size_ext = SW'(MAX_WINDOW);
    end else begin
      size_ext = wc_ext;
    end
  end

  assign held     = fill_r + CW'(1);
  assign held_ext = SW'(held);
  assign close    = (held_ext >= size_ext);
  assign fill_nxt = close ? '0 : held;

  assign in_if.ready = unit_idle;
  assign accept      = in_if.valid && unit_idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  bmf_insert_unit #(.MAX_WINDOW(MAX_WINDOW)) u_insert (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .key       (in_if.sample),
    .pos       (fill_r[AW-1:0]),
    .close     (close),
    .med_addr  (AW'(held >> 1)),
    .idle      (unit_idle),
    .res_valid (res_valid),
    .res_data  (res_data),
    .take      (take)
  );

  // output word register
  assign take = res_valid && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_data_r <= res_data;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.median_value = out_data_r;

endmodule
`default_nettype wire
